// File: rtl/core/quaternion_fundamental_region_macros.svh
// Assertion macros for the quaternion fundamental region block.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef QUATERNION_FUNDAMENTAL_REGION_MACROS_SVH
`define QUATERNION_FUNDAMENTAL_REGION_MACROS_SVH

// same-cycle implication
`define QFR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/qfr_pkg.sv
// Package for the quaternion fundamental region block: widths, codes, types.
// Holds the quaternion product term tables. No dependencies.
package qfr_pkg;

	localparam int MAX_SYM   = 24;
	localparam int FRAC_BITS = 14;
	localparam int IDX_W     = 5;
	localparam int DW        = 16;
	localparam int MW        = 20;
	localparam int PW        = 2 * MW;
	localparam int ACC_W     = 34;
	localparam int MAG_W     = 19;
	localparam int ROOT_W    = 20;
	localparam int NUM_W     = 34;
	localparam int Q_W       = 15;
	localparam int CNT_W     = 5;
	localparam int CFG_W     = 16;

	localparam logic signed [MW-1:0] ONE_S = MW'(1 << FRAC_BITS);

	// operand selects for the 16 product terms, term t at bits [2t+1:2t]
	localparam logic [31:0] R_SEL    = 32'h63D2_B1E4;
	localparam logic [31:0] Q_SEL    = 32'h9C78_E4E4;
	localparam logic [15:0] TERM_NEG = 16'h888E;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_REDUCE = 1'b1
	} opcode_t;

	typedef enum logic {
		CFG_SYM_COUNT  = 1'b0,
		CFG_NORM_FLOOR = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MAC,
		ST_RND,
		ST_SQ,
		ST_RSTART,
		ST_ROOT,
		ST_CHK,
		ST_DSTART,
		ST_DIV,
		ST_SEL,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic       vld;
		logic       sq;
		logic [1:0] j;
		logic       neg;
	} tag_t;

	function automatic logic [1:0] r_sel(logic [3:0] t);
		return R_SEL[{t, 1'b0} +: 2];
	endfunction

	function automatic logic [1:0] q_sel(logic [3:0] t);
		return Q_SEL[{t, 1'b0} +: 2];
	endfunction

	function automatic logic [MAG_W-1:0] mag_of(logic signed [MW-1:0] v);
		logic signed [MW-1:0] n;
		n = v[MW-1] ? -v : v;
		return n[MAG_W-1:0];
	endfunction

endpackage

// File: rtl/core/qfr_if.sv
// Handshake interfaces: item input, result output and configuration write.
// Depends on qfr_pkg.
interface qfr_item_if;
	import qfr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 opcode;
	logic [IDX_W-1:0]     sym_slot;
	logic signed [DW-1:0] in_w;
	logic signed [DW-1:0] in_x;
	logic signed [DW-1:0] in_y;
	logic signed [DW-1:0] in_z;
	modport source (output valid, opcode, sym_slot, in_w, in_x, in_y, in_z, input ready);
	modport sink (input valid, opcode, sym_slot, in_w, in_x, in_y, in_z, output ready);
endinterface

interface qfr_res_if;
	import qfr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] out_w;
	logic signed [DW-1:0] out_x;
	logic signed [DW-1:0] out_y;
	logic signed [DW-1:0] out_z;
	logic [IDX_W-1:0]     best_op;
	modport source (output valid, out_w, out_x, out_y, out_z, best_op, input ready);
	modport sink (input valid, out_w, out_x, out_y, out_z, best_op, output ready);
endinterface

interface qfr_cfg_if;
	import qfr_pkg::*;
	logic             valid;
	logic             ready;
	logic             index;
	logic [CFG_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/qfr_mul.sv
// Shared signed multiplier with registered product.
// Depends on qfr_pkg.
module qfr_mul (
	input  logic                          clk,
	input  logic signed [qfr_pkg::MW-1:0] a,
	input  logic signed [qfr_pkg::MW-1:0] b,
	output logic signed [qfr_pkg::PW-1:0] p_s1
);
	import qfr_pkg::*;

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

// File: rtl/core/qfr_isqrt.sv
// Bit-serial integer square root, two operand bits per cycle.
// Depends on qfr_pkg.
module qfr_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [2*qfr_pkg::ROOT_W-1:0]  opd,
	output logic                          done,
	output logic [qfr_pkg::ROOT_W-1:0]    root
);
	import qfr_pkg::*;

	logic [2*ROOT_W-1:0] opd_q;
	logic [ROOT_W+1:0]   rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                run_q;
	logic                done_q;
	logic [ROOT_W+1:0]   rem_n;
	logic [ROOT_W+1:0]   trial;

	assign rem_n = {rem_q[ROOT_W-1:0], opd_q[2*ROOT_W-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign done  = done_q;
	assign root  = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			opd_q  <= opd;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			opd_q <= {opd_q[2*ROOT_W-3:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(ROOT_W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

// File: rtl/core/qfr_div.sv
// Restoring divider, one quotient bit per cycle; quotient known below 2^Q_W.
// Depends on qfr_pkg.
module qfr_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [qfr_pkg::NUM_W-1:0]    num,
	input  logic [qfr_pkg::ROOT_W-1:0]   den,
	output logic                         done,
	output logic [qfr_pkg::Q_W-1:0]      quo
);
	import qfr_pkg::*;

	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] d_q;
	logic [Q_W-1:0]   quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic             ge;

	assign ge   = rem_q >= d_q;
	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			rem_q  <= num;
			d_q    <= NUM_W'({den, {(Q_W-1){1'b0}}});
			quo_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - d_q;
			end
			quo_q <= {quo_q[Q_W-2:0], ge};
			d_q   <= d_q >> 1;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(Q_W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

// File: rtl/core/quaternion_fundamental_region.sv
// Reduces a Q2.14 orientation quaternion to the fundamental region of a loaded symmetry
// table. A load transaction writes one table slot. A reduce transaction walks the first
// sym_count operators (clamped to 1..MAX_SYM), each with a fetch, 16 products and a
// drain on the one shared multiplier, 4 roundings, 4 squares and a drain, a 20-step
// bit-serial root with its start and check, and four 15-step divisions; it then
// renormalises the winner and moves it to the output register in ST_FIN once that
// register is free; an operator whose norm falls below norm_floor skips the divisions.
// Item inputs are not taken while a reduction runs; one finished result is held in the
// output register.
// Depends on qfr_pkg, qfr_if, qfr_mul, qfr_isqrt, qfr_div and the macros header.
module quaternion_fundamental_region (
	input logic        clk,
	input logic        arst_n,
	qfr_item_if.sink   item,
	qfr_res_if.source  result,
	qfr_cfg_if.sink    cfg
);
	import qfr_pkg::*;
	`include "quaternion_fundamental_region_macros.svh"

	state_t state_q, state_d;

	logic signed [DW-1:0]  tbl_q [MAX_SYM][4];
	logic signed [DW-1:0]  q_q [4];
	logic signed [DW-1:0]  symr_q [4];
	logic signed [ACC_W-1:0] acc_q [4];
	logic signed [MW-1:0]  comp_q [4];
	logic [MAG_W-1:0]      mag_q [4];
	logic signed [DW-1:0]  best_q [4];
	logic [2*ROOT_W-1:0]   sumsq_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      count_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  final_q;
	logic [IDX_W-1:0]      sym_count_q;
	logic [DW-2:0]         norm_floor_q;
	logic                  ov_q;
	logic signed [DW-1:0]  res_q [4];
	logic [IDX_W-1:0]      res_idx_q;
	tag_t                  tag_d, tag_s1;

	logic signed [MW-1:0]  mul_a, mul_b;
	logic signed [PW-1:0]  p_s1;
	logic                  root_go, root_done, div_go, div_done;
	logic [ROOT_W-1:0]     root;
	logic [Q_W-1:0]        quo;
	logic [NUM_W-1:0]      div_num;
	logic signed [DW-1:0]  ra, qa;
	logic [1:0]            j;
	logic signed [ACC_W-1:0] rv;
	logic [ACC_W-1:0]      rm;
	logic [ACC_W:0]        rs;
	logic [MAG_W-1:0]      rr;
	logic                  ident, upd, last, out_load;
	logic [IDX_W-1:0]      clamp;

	assign j       = cnt_q[1:0];
	assign ra      = symr_q[r_sel(cnt_q[3:0])];
	assign qa      = q_q[q_sel(cnt_q[3:0])];
	assign rv      = acc_q[0][ACC_W-1] ? -acc_q[j] : acc_q[j];
	assign rm      = rv[ACC_W-1] ? ACC_W'(-rv) : ACC_W'(rv);
	assign rs      = {1'b0, rm} + (ACC_W+1)'(1 << (FRAC_BITS - 1));
	assign rr      = rs[FRAC_BITS +: MAG_W];
	assign ident   = (root == '0) || (root < ROOT_W'(norm_floor_q));
	assign div_num = NUM_W'({mag_q[j], {FRAC_BITS{1'b0}}}) + NUM_W'(root >> 1);
	assign upd     = (idx_q == '0) || (comp_q[0] > MW'(best_q[0]));
	assign last    = (idx_q + 1'b1) == count_q;
	assign out_load = (state_q == ST_FIN) && (!ov_q || result.ready);
	assign clamp   = (sym_count_q == '0) ? IDX_W'(1) :
		(sym_count_q > IDX_W'(MAX_SYM)) ? IDX_W'(MAX_SYM) : sym_count_q;

	assign cfg.ready      = 1'b1;
	assign result.valid   = ov_q;
	assign result.out_w   = res_q[0];
	assign result.out_x   = res_q[1];
	assign result.out_y   = res_q[2];
	assign result.out_z   = res_q[3];
	assign result.best_op = res_idx_q;

	qfr_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_s1(p_s1));

	qfr_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(root_go), .opd(sumsq_q),
		.done(root_done), .root(root)
	);

	qfr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num(div_num), .den(root),
		.done(div_done), .quo(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mul_a      = '0;
		mul_b      = '0;
		root_go    = 1'b0;
		div_go     = 1'b0;
		tag_d      = '0;
		item.ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (item.valid && item.opcode == OP_REDUCE) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_MAC;
			ST_MAC: begin
				if (cnt_q < CNT_W'(16)) begin
					mul_a     = MW'(ra);
					mul_b     = MW'(qa);
					tag_d.vld = 1'b1;
					tag_d.j   = cnt_q[3:2];
					tag_d.neg = TERM_NEG[cnt_q[3:0]];
				end else begin
					state_d = ST_RND;
				end
			end
			ST_RND: begin
				if (j == 2'd3) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				if (cnt_q < CNT_W'(4)) begin
					mul_a     = MW'({1'b0, mag_q[j]});
					mul_b     = MW'({1'b0, mag_q[j]});
					tag_d.vld = 1'b1;
					tag_d.sq  = 1'b1;
				end else begin
					state_d = ST_RSTART;
				end
			end
			ST_RSTART: begin
				root_go = 1'b1;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (root_done) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: state_d = ident ? ST_SEL : ST_DSTART;
			ST_DSTART: begin
				div_go  = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = (j == 2'd3) ? ST_SEL : ST_DSTART;
				end
			end
			ST_SEL: state_d = final_q ? ST_FIN : (last ? ST_SQ : ST_FETCH);
			ST_FIN: begin
				if (!ov_q || result.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1       <= '0;
			cnt_q        <= '0;
			idx_q        <= '0;
			final_q      <= 1'b0;
			ov_q         <= 1'b0;
			sym_count_q  <= IDX_W'(1);
			norm_floor_q <= (DW-1)'(1);
		end else begin
			tag_s1 <= tag_d;
			if (cfg.valid) begin
				case (cfg_idx_t'(cfg.index))
					CFG_SYM_COUNT:  sym_count_q  <= cfg.data[IDX_W-1:0];
					CFG_NORM_FLOOR: norm_floor_q <= cfg.data[DW-2:0];
					default: ;
				endcase
			end
			if (tag_s1.vld) begin
				if (tag_s1.sq) begin
					sumsq_q <= sumsq_q + p_s1[2*ROOT_W-1:0];
				end else if (tag_s1.neg) begin
					acc_q[tag_s1.j] <= acc_q[tag_s1.j] - p_s1[ACC_W-1:0];
				end else begin
					acc_q[tag_s1.j] <= acc_q[tag_s1.j] + p_s1[ACC_W-1:0];
				end
			end
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						if (item.opcode == OP_LOAD) begin
							if (item.sym_slot < IDX_W'(MAX_SYM)) begin
								tbl_q[item.sym_slot][0] <= item.in_w;
								tbl_q[item.sym_slot][1] <= item.in_x;
								tbl_q[item.sym_slot][2] <= item.in_y;
								tbl_q[item.sym_slot][3] <= item.in_z;
							end
						end else begin
							q_q[0]  <= item.in_w;
							q_q[1]  <= item.in_x;
							q_q[2]  <= item.in_y;
							q_q[3]  <= item.in_z;
							count_q <= clamp;
							idx_q   <= '0;
							final_q <= 1'b0;
						end
					end
				end
				ST_FETCH: begin
					for (int k = 0; k < 4; k++) begin
						symr_q[k] <= tbl_q[idx_q][k];
						acc_q[k]  <= '0;
					end
					cnt_q <= '0;
				end
				ST_MAC: begin
					cnt_q <= (cnt_q < CNT_W'(16)) ? cnt_q + 1'b1 : '0;
				end
				ST_RND: begin
					mag_q[j]  <= rr;
					comp_q[j] <= rv[ACC_W-1] ? -MW'(rr) : MW'(rr);
					if (j == 2'd3) begin
						cnt_q   <= '0;
						sumsq_q <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQ: cnt_q <= cnt_q + 1'b1;
				ST_RSTART: cnt_q <= '0;
				ST_CHK: begin
					if (ident) begin
						comp_q[0] <= ONE_S;
						comp_q[1] <= '0;
						comp_q[2] <= '0;
						comp_q[3] <= '0;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						comp_q[j] <= comp_q[j][MW-1] ? -MW'(quo) : MW'(quo);
						cnt_q     <= cnt_q + 1'b1;
					end
				end
				ST_SEL: begin
					if (!final_q) begin
						if (upd) begin
							for (int k = 0; k < 4; k++) begin
								best_q[k] <= comp_q[k][DW-1:0];
							end
							best_idx_q <= idx_q;
						end
						if (last) begin
							for (int k = 0; k < 4; k++) begin
								comp_q[k] <= upd ? comp_q[k] : MW'(best_q[k]);
								mag_q[k]  <= mag_of(upd ? comp_q[k] : MW'(best_q[k]));
							end
							final_q <= 1'b1;
							sumsq_q <= '0;
							cnt_q   <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (out_load) begin
						for (int k = 0; k < 4; k++) begin
							res_q[k] <= comp_q[k][DW-1:0];
						end
						res_idx_q <= best_idx_q;
					end
				end
				default: ;
			endcase
		end
	end

	`QFR_ASSERT_NEXT(a_reduce_starts, item.valid && item.ready && item.opcode == OP_REDUCE, state_q == ST_FETCH, "reduce transaction did not start")
	`QFR_ASSERT_SAME(a_result_from_fin, $rose(ov_q), $past(state_q) == ST_FIN, "result raised outside finish")
	`QFR_ASSERT_SAME(a_cand_scalar, state_q == ST_SEL, comp_q[0] >= 0 && comp_q[0] <= ONE_S, "candidate scalar out of range")
	`QFR_ASSERT_SAME(a_best_op_range, ov_q, res_idx_q < IDX_W'(MAX_SYM), "best_op beyond table")

endmodule
